[src/rrbs_pkg.sv]
// Shared types and constants for the ROM/RAM bank switch mapper.
// No dependencies.
`default_nettype none

package rrbs_pkg;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Read targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;

  // 8 KiB bus segments, address[15:13]
  localparam logic [2:0] SEG_0000 = 3'd0;  // ROM bank 0 / RAM enable write
  localparam logic [2:0] SEG_2000 = 3'd1;  // ROM bank 0 / low bank write
  localparam logic [2:0] SEG_4000 = 3'd2;  // switchable ROM / upper bits write
  localparam logic [2:0] SEG_6000 = 3'd3;  // switchable ROM / mode write
  localparam logic [2:0] SEG_A000 = 3'd5;  // external RAM

  // Config register map
  localparam int unsigned  CFG_ADDR_W        = 3;
  localparam logic         REG_ROM_SIZE_CODE = 1'b0;  // word index, paddr[2]
  localparam logic [3:0]   ROM_CODE_SMALL_MAX = 4'd4;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] phys_address;
    logic [7:0]  ram_enable_value;
  } out_item_t;

  typedef struct packed {
    logic [4:0] rom_bank_low;
    logic [1:0] rom_bank_high;
    logic [1:0] ram_bank;
    logic       bank_mode;
    logic [7:0] ram_enable_reg;
  } bank_state_t;

  // Low bank bits kept for a given ROM size code: code+1 bits, at most five.
  function automatic logic [4:0] low_bank_mask(input logic [3:0] code);
    logic [4:0] m;
    m = 5'h1F;
    if (code < ROM_CODE_SMALL_MAX) begin
      m = 5'((5'd2 << code[1:0]) - 5'd1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[src/rrbs_cfg.sv]
// APB-style config register holding the ROM size code.
// Depends on rrbs_pkg.
`default_nettype none

module rrbs_cfg
  import rrbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output logic      [3:0]            rom_size_code
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ROM_SIZE_CODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_code <= 4'd0;
    end else if (wr_hit) begin
      rom_size_code <= pwdata[3:0];
    end
  end

  // bytes within the word are not decoded
  assign prdata = (paddr[2] == REG_ROM_SIZE_CODE) ? {28'd0, rom_size_code} : 32'd0;

endmodule

`default_nettype wire

[src/rrbs_bank_regs.sv]
// Bank control registers and their write decode.
// Depends on rrbs_pkg.
`default_nettype none

module rrbs_bank_regs
  import rrbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        upd,
  input  wire in_item_t    item,
  input  wire logic [3:0]  rom_size_code,
  output bank_state_t      st_next
);

  bank_state_t st;

  always_comb begin
    st_next = st;
    if (item.op == OP_WRITE) begin
      unique case (item.address[15:13])
        SEG_0000: st_next.ram_enable_reg = item.value;
        SEG_2000: begin
          st_next.rom_bank_low  = item.value[4:0] & low_bank_mask(rom_size_code);
          st_next.rom_bank_high = 2'd0;
        end
        SEG_4000: begin
          if (rom_size_code > ROM_CODE_SMALL_MAX) begin
            st_next.rom_bank_high = item.value[1:0];
          end else if (st.bank_mode) begin
            st_next.ram_bank = item.value[1:0];
          end
        end
        SEG_6000: st_next.bank_mode = item.value[0];
        default: ;  // writes above 0x7FFF are ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.rom_bank_low   <= 5'd1;
      st.rom_bank_high  <= 2'd0;
      st.ram_bank       <= 2'd0;
      st.bank_mode      <= 1'b0;
      st.ram_enable_reg <= 8'd0;
    end else if (upd) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

[src/rrbs_map.sv]
// Read address translation to ROM or external RAM.
// Depends on rrbs_pkg.
`default_nettype none

module rrbs_map
  import rrbs_pkg::*;
(
  input  wire in_item_t    item,
  input  wire bank_state_t st,
  output out_item_t        res
);

  logic [4:0] low;

  // bank 0 in the low bits always selects bank 1
  assign low = (st.rom_bank_low == 5'd0) ? 5'd1 : st.rom_bank_low;

  always_comb begin
    res.target           = TGT_NONE;
    res.phys_address     = 21'd0;
    res.ram_enable_value = st.ram_enable_reg;
    if (item.op == OP_READ) begin
      unique case (item.address[15:13]) inside
        SEG_0000, SEG_2000: begin
          res.target       = TGT_ROM;
          res.phys_address = {5'd0, item.address};
        end
        SEG_4000, SEG_6000: begin
          res.target       = TGT_ROM;
          res.phys_address = {st.rom_bank_high, low, item.address[13:0]};
        end
        SEG_A000: begin
          res.target       = TGT_RAM;
          res.phys_address = {6'd0, st.ram_bank, item.address[12:0]};
        end
        default: ;  // unmapped
      endcase
    end
  end

endmodule

`default_nettype wire

[src/rom_ram_bank_switch_mapper_unit.sv]
// ROM/RAM bank switch mapper, top level.
// Depends on rrbs_pkg, rrbs_cfg, rrbs_bank_regs, rrbs_map.
//
// Usage:
//  - in_valid/in_ready/in_data carry one bus access per transfer: op (read or
//    write), 16-bit address, write byte.
//  - out_valid/out_ready/out_data carry exactly one result per access: target,
//    21-bit physical address, and the RAM enable byte after the access.
//  - APB port holds rom_size_code at byte address 0; write it only while idle.
// Timing:
//  - Two register stages: an input register and a result register. An access
//    waits in the input register until the result register is free or
//    draining, then moves into it and out_valid rises.
//  - One access per cycle sustained while out_ready stays high; the decode and
//    register update between the stages are a few gate levels deep.
//  - Bank registers update as an access moves from the input stage to the
//    result stage, so accesses see all earlier writes in order.
// Reset (rst, synchronous): both stages empty, low ROM bank 1, other bank
//   registers and rom_size_code zero.
// Stall: while out_ready is low the result holds; the input stage still takes
//   one more transfer, then in_ready drops until the result drains.
`default_nettype none

module rom_ram_bank_switch_mapper_unit
  import rrbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // access channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  // config port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  logic [3:0]  rom_size_code;
  in_item_t    in_reg;
  logic        in_full;
  logic        advance;
  bank_state_t st_next;
  out_item_t   res;

  rrbs_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .rom_size_code (rom_size_code)
  );

  // input stage moves on when the result register is free or being drained
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  rrbs_bank_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .upd           (advance),
    .item          (in_reg),
    .rom_size_code (rom_size_code),
    .st_next       (st_next)
  );

  // reads leave the state alone, so the next state serves both cases
  rrbs_map u_map (
    .item (in_reg),
    .st   (st_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

[tb/sv/rom_ram_bank_switch_mapper_unit_tb.sv]
// Self-checking testbench for rom_ram_bank_switch_mapper_unit: bus accesses in,
// translated addresses out, checked against an in-bench bank model.
// Depends on rrbs_pkg and the mapper RTL.
`timescale 1ns / 100ps

module rom_ram_bank_switch_mapper_unit_tb;
  import rrbs_pkg::*;

  typedef struct {
    bit         cfg;      // row writes rom_size_code instead of issuing an access
    logic [3:0] code;
    in_item_t   acc;
    bit         pinned;   // result typed in below rather than computed
    out_item_t  want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // bank model state
  logic [3:0] size_code;
  logic [4:0] bank_low;
  logic [1:0] bank_high;
  logic [1:0] ram_sel;
  logic       upper_mode;
  logic [7:0] enable_byte;

  step_row_t issued_accesses[$];
  out_item_t translations_due[$];
  step_row_t plan[$];
  int unsigned mismatch_count = 0;
  bit steady = 1'b0;   // no idling on either side while set

  rom_ram_bank_switch_mapper_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Applies one access to the bank model and returns its translation.
  function automatic out_item_t map_access(input in_item_t acc);
    out_item_t  r;
    logic [4:0] low_used;
    r = '0;
    if (acc.op == OP_WRITE) begin
      if (acc.address < 16'h2000) begin
        enable_byte = acc.value;
      end else if (acc.address < 16'h4000) begin
        bank_low  = acc.value[4:0] & 5'((32'd1 << (size_code + 1)) - 1);
        bank_high = 2'd0;
      end else if (acc.address < 16'h6000) begin
        if (size_code > 4'd4) begin
          bank_high = acc.value[1:0];
        end else if (upper_mode) begin
          ram_sel = acc.value[1:0];
        end
      end else if (acc.address < 16'h8000) begin
        upper_mode = acc.value[0];
      end
    end else if (acc.address < 16'h4000) begin
      r.target       = TGT_ROM;
      r.phys_address = {5'd0, acc.address};
    end else if (acc.address < 16'h8000) begin
      // bank 0 is never selectable in the switchable window
      low_used       = (bank_low == 5'd0) ? 5'd1 : bank_low;
      r.target       = TGT_ROM;
      r.phys_address = {bank_high, low_used, acc.address[13:0]};
    end else if (acc.address >= 16'hA000 && acc.address < 16'hC000) begin
      r.target       = TGT_RAM;
      r.phys_address = {6'd0, ram_sel, acc.address[12:0]};
    end
    r.ram_enable_value = enable_byte;
    return r;
  endfunction

  function automatic step_row_t row_open(input logic op, input logic [15:0] a,
                                         input logic [7:0] v);
    step_row_t s;
    s = '{cfg: 1'b0, code: 4'd0, acc: '{op: op, address: a, value: v},
          pinned: 1'b0, want: '0};
    return s;
  endfunction

  function automatic step_row_t row_pinned(input logic op, input logic [15:0] a,
                                           input logic [7:0] v, input logic [1:0] t,
                                           input logic [20:0] p, input logic [7:0] e);
    step_row_t s;
    s = row_open(op, a, v);
    s.pinned = 1'b1;
    s.want   = '{target: t, phys_address: p, ram_enable_value: e};
    return s;
  endfunction

  function automatic step_row_t row_cfg(input logic [3:0] code);
    step_row_t s;
    s = row_open(OP_READ, 16'h0000, 8'h00);
    s.cfg  = 1'b1;
    s.code = code;
    return s;
  endfunction

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    mismatch_count++;
  endtask

  // Result side is checked before the access side: with two register stages a
  // transfer in can never come out at the same edge.
  always @(posedge clk) begin : bus_watch
    step_row_t sent;
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (translations_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual 0x%0h",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want = translations_due.pop_front();
          if (out_data.target !== want.target)
            note_mismatch("target", want.target, out_data.target);
          if (out_data.phys_address !== want.phys_address)
            note_mismatch("phys_address", want.phys_address, out_data.phys_address);
          if (out_data.ram_enable_value !== want.ram_enable_value)
            note_mismatch("ram_enable_value", want.ram_enable_value,
                          out_data.ram_enable_value);
        end
      end
      if (in_valid && in_ready) begin
        sent = issued_accesses.pop_front();
        want = map_access(sent.acc);
        if (sent.pinned) want = sent.want;
        translations_due.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 13);
  end

  task automatic send_access(input step_row_t s);
    if (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    issued_accesses.push_back(s);
    in_valid <= 1'b1;
    in_data  <= s.acc;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender holds off until every translation is back and the pipe is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (translations_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_rom_size(input logic [3:0] code);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_ROM_SIZE_CODE, 2'b00};
    pwdata  <= {28'd0, code};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_code = code;
  endtask

  initial begin
    in_item_t acc;
    int unsigned r;
    size_code   = 4'd0;
    bank_low    = 5'd1;
    bank_high   = 2'd0;
    ram_sel     = 2'd0;
    upper_mode  = 1'b0;
    enable_byte = 8'd0;

    // decode extremes from reset state
    plan.push_back(row_cfg(4'd0));
    plan.push_back(row_pinned(OP_READ,  16'h0000, 8'h00, TGT_ROM,  21'h000000, 8'h00));
    plan.push_back(row_pinned(OP_READ,  16'h3FFF, 8'h00, TGT_ROM,  21'h003FFF, 8'h00));
    plan.push_back(row_pinned(OP_READ,  16'h4000, 8'h00, TGT_ROM,  21'h004000, 8'h00));
    plan.push_back(row_pinned(OP_READ,  16'h7FFF, 8'h00, TGT_ROM,  21'h007FFF, 8'h00));
    plan.push_back(row_pinned(OP_READ,  16'h8000, 8'h00, TGT_NONE, 21'h000000, 8'h00));
    plan.push_back(row_pinned(OP_READ,  16'hA000, 8'h00, TGT_RAM,  21'h000000, 8'h00));
    plan.push_back(row_pinned(OP_READ,  16'hBFFF, 8'h00, TGT_RAM,  21'h001FFF, 8'h00));
    plan.push_back(row_pinned(OP_READ,  16'hC000, 8'h00, TGT_NONE, 21'h000000, 8'h00));
    plan.push_back(row_pinned(OP_READ,  16'hFFFF, 8'hFF, TGT_NONE, 21'h000000, 8'h00));
    // enable byte is only recorded
    plan.push_back(row_pinned(OP_WRITE, 16'h0000, 8'hFF, TGT_NONE, 21'h000000, 8'hFF));
    plan.push_back(row_pinned(OP_WRITE, 16'h1FFF, 8'h0A, TGT_NONE, 21'h000000, 8'h0A));
    // low bank zero reads as bank 1
    plan.push_back(row_pinned(OP_WRITE, 16'h2000, 8'h00, TGT_NONE, 21'h000000, 8'h0A));
    plan.push_back(row_pinned(OP_READ,  16'h4000, 8'h00, TGT_ROM,  21'h004000, 8'h0A));
    // small ROM, mode 0: upper write is dropped
    plan.push_back(row_pinned(OP_WRITE, 16'h4000, 8'h03, TGT_NONE, 21'h000000, 8'h0A));
    plan.push_back(row_pinned(OP_READ,  16'hA000, 8'h00, TGT_RAM,  21'h000000, 8'h0A));
    // mode 1 lets the upper write pick the RAM bank
    plan.push_back(row_pinned(OP_WRITE, 16'h6000, 8'hFF, TGT_NONE, 21'h000000, 8'h0A));
    plan.push_back(row_pinned(OP_WRITE, 16'h5FFF, 8'hFF, TGT_NONE, 21'h000000, 8'h0A));
    plan.push_back(row_pinned(OP_READ,  16'hBFFF, 8'h00, TGT_RAM,  21'h007FFF, 8'h0A));
    // writes above the register window are ignored
    plan.push_back(row_pinned(OP_WRITE, 16'h8000, 8'hFF, TGT_NONE, 21'h000000, 8'h0A));
    plan.push_back(row_pinned(OP_WRITE, 16'hFFFF, 8'h00, TGT_NONE, 21'h000000, 8'h0A));
    // large ROM: bank 0x20 reads as 0x21, then the top bank
    plan.push_back(row_cfg(4'd8));
    plan.push_back(row_open(OP_WRITE, 16'h3FFF, 8'hE0));
    plan.push_back(row_open(OP_WRITE, 16'h4000, 8'h01));
    plan.push_back(row_pinned(OP_READ,  16'h4000, 8'h00, TGT_ROM,  21'h084000, 8'h0A));
    plan.push_back(row_open(OP_WRITE, 16'h2000, 8'hFF));
    plan.push_back(row_open(OP_WRITE, 16'h7FFF, 8'hFE));
    plan.push_back(row_open(OP_WRITE, 16'h4000, 8'hFF));
    plan.push_back(row_pinned(OP_READ,  16'h7FFF, 8'h00, TGT_ROM,  21'h1FFFFF, 8'h0A));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        wait_drained();
        write_rom_size(plan[i].code);
      end else begin
        send_access(plan[i]);
      end
    end

    // nine phases, each at its own size code; (5*p)%9 visits 0..8 once
    for (int p = 0; p < 9; p++) begin
      wait_drained();
      write_rom_size(4'((5 * p) % 9));
      steady = (p == 4);
      repeat (45) begin
        r = $urandom_range(0, 99);
        acc.op    = OP_WRITE;
        acc.value = 8'($urandom);
        if (r < 12) begin
          acc.address = {SEG_0000, 13'($urandom)};
        end else if (r < 24) begin
          acc.address = {SEG_2000, 13'($urandom)};
        end else if (r < 34) begin
          acc.address = {SEG_4000, 13'($urandom)};
        end else if (r < 40) begin
          acc.address = {SEG_6000, 13'($urandom)};
        end else if (r < 44) begin
          acc.address = {1'b1, 15'($urandom)};
        end else begin
          acc.op = OP_READ;
          if (r < 62) begin
            acc.address = {2'b01, 14'($urandom)};
          end else if (r < 72) begin
            acc.address = {2'b00, 14'($urandom)};
          end else if (r < 84) begin
            acc.address = {SEG_A000, 13'($urandom)};
          end else if (r < 90) begin
            acc.address = $urandom_range(0, 1) ? {3'b100, 13'($urandom)}
                                               : {2'b11, 14'($urandom)};
          end else begin
            acc.op      = 1'($urandom);
            acc.address = 16'($urandom);
          end
        end
        send_access(row_open(acc.op, acc.address, acc.value));
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
